[hdl/rk4o_pkg.sv]
// ----------------------------------------------------------------------------
// rk4o_pkg - shared types and constants for the RK4 oscillator stepper
// Fixed-point formats, register indexes, opcodes and the sequencer states.
// ----------------------------------------------------------------------------
package rk4o_pkg;

   // signed fixed point word, Q8.24
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;

   // exact weighted sum k1 + 2k2 + 2k3 + k4 of four words
   localparam int SUM_BITS  = WORD_BITS + 4;

   // digit-serial divide by six, four bits per cycle
   localparam int DIV_BITS      = SUM_BITS + 4;
   localparam int DIV_DIGITS    = DIV_BITS / 4;
   localparam int DIV_CNT_BITS  = $clog2(DIV_DIGITS);

   // configuration register widths
   localparam int DAMPING_BITS   = 31;
   localparam int STIFFNESS_BITS = 31;
   localparam int TIME_STEP_BITS = 25;
   localparam int STEP_BITS      = 20;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 31;

   localparam logic [DAMPING_BITS-1:0]   DAMPING_RESET   = 31'd0;
   localparam logic [STIFFNESS_BITS-1:0] STIFFNESS_RESET = 31'd167772160;
   localparam logic [TIME_STEP_BITS-1:0] TIME_STEP_RESET = 25'd16777;
   localparam logic [STEP_BITS-1:0]      STEP_LIMIT_RESET = 20'd30000;

   // RK4 stage counter
   localparam int STAGE_BITS = 2;
   localparam logic [STAGE_BITS-1:0] STAGE_FULL = 2'd2;  // stage that uses the whole k
   localparam logic [STAGE_BITS-1:0] STAGE_LAST = 2'd3;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [SUM_BITS-1:0]  sum_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DAMPING    = 2'd0,
      CSR_STIFFNESS  = 2'd1,
      CSR_TIME_STEP  = 2'd2,
      CSR_STEP_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_KX,
      ST_MUL_DV,
      ST_MUL_VDT,
      ST_ACCEL,
      ST_MUL_ADT,
      ST_ROUND_DV,
      ST_VEL_MID,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_UPDATE,
      ST_RESULT
   } state_type;

endpackage

[hdl/rk4o_req_if.sv]
// ----------------------------------------------------------------------------
// rk4o_req_if - request channel of the RK4 oscillator stepper
// Valid/ready channel carrying an opcode and the load values.
// ----------------------------------------------------------------------------
interface rk4o_req_if;
   logic                             valid;
   logic                             ready;
   logic                             opcode;
   logic signed [rk4o_pkg::WORD_BITS-1:0] start_position;
   logic signed [rk4o_pkg::WORD_BITS-1:0] start_velocity;

   modport source (output valid, output opcode, output start_position,
                   output start_velocity, input ready);
   modport sink   (input valid, input opcode, input start_position,
                   input start_velocity, output ready);
endinterface

[hdl/rk4o_rsp_if.sv]
// ----------------------------------------------------------------------------
// rk4o_rsp_if - response channel of the RK4 oscillator stepper
// Valid/ready channel carrying the state after each request.
// ----------------------------------------------------------------------------
interface rk4o_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [31:0]                    position;
   logic signed [31:0]                    velocity;
   logic [rk4o_pkg::STEP_BITS-1:0]        steps_done;
   logic                                  crossed_zero;
   logic                                  finished;

   modport source (output valid, output position, output velocity, output steps_done,
                   output crossed_zero, output finished, input ready);
   modport sink   (input valid, input position, input velocity, input steps_done,
                   input crossed_zero, input finished, output ready);
endinterface

[hdl/rk4o_mul.sv]
// ----------------------------------------------------------------------------
// rk4o_mul - shared fixed-point multiplier
// Registered signed product, then round to nearest (ties away from zero),
// drop the fraction bits and saturate to the word.
// ----------------------------------------------------------------------------
module rk4o_mul (
   input  logic               clock,
   input  rk4o_pkg::word_type mul_a,
   input  rk4o_pkg::word_type mul_b,
   output rk4o_pkg::word_type mul_res
);
   import rk4o_pkg::*;

   logic signed [2*WORD_BITS-1:0] prod_ff;
   logic signed [2*WORD_BITS-1:0] prod_in;
   logic signed [2*WORD_BITS-1:0] rnd;
   logic signed [2*WORD_BITS-1:0] shifted;
   logic                          ovf;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // ties away from zero: add half, minus one ulp for negative products
   always_comb begin
      rnd = prod_ff + (2*WORD_BITS)'(64'd1 << (FRAC_BITS - 1))
            - (2*WORD_BITS)'(prod_ff[2*WORD_BITS-1]);
      shifted = rnd >>> FRAC_BITS;
      ovf = !((&shifted[2*WORD_BITS-1:WORD_BITS-1]) ||
              (~|shifted[2*WORD_BITS-1:WORD_BITS-1]));
      if (ovf) begin
         mul_res = shifted[2*WORD_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                          : {1'b0, {(WORD_BITS-1){1'b1}}};
      end else begin
         mul_res = shifted[WORD_BITS-1:0];
      end
   end

endmodule

[hdl/rk4o_div6.sv]
// ----------------------------------------------------------------------------
// rk4o_div6 - two-lane digit-serial divide by six
// Computes floor((sum + 3) / 6) for two sums, one hex digit per cycle,
// and saturates the quotients to the word.
// ----------------------------------------------------------------------------
module rk4o_div6 (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  rk4o_pkg::sum_type  sum_x,
   input  rk4o_pkg::sum_type  sum_v,
   output logic               done,
   output rk4o_pkg::word_type quo_x,
   output rk4o_pkg::word_type quo_v
);
   import rk4o_pkg::*;

   // bias keeps the dividend positive; it is a multiple of six
   localparam logic [DIV_BITS-1:0] DIV_BIAS   = DIV_BITS'(6) << (SUM_BITS - 2);
   localparam logic [DIV_BITS-1:0] QUO_OFFSET = DIV_BITS'(1) << (SUM_BITS - 2);

   logic [DIV_BITS-1:0]     dvd_ff [2];
   logic [DIV_BITS-1:0]     dvd_in [2];
   logic [DIV_BITS-1:0]     quo_ff [2];
   logic [DIV_BITS-1:0]     quo_in [2];
   logic [2:0]              rem_ff [2];
   logic [2:0]              rem_in [2];
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   sum_type                 sum_lane [2];
   word_type                quo_out [2];

   // one quotient digit: value below 96, reciprocal of six is 43/256 here
   function automatic logic [6:0] div6_digit(input logic [6:0] val);
      logic [13:0] prod;
      logic [3:0]  q;
      logic [6:0]  r;
      prod = 14'(val) * 14'd43;
      q    = prod[11:8];
      r    = val - 7'(q) * 7'd6;
      return {q, r[2:0]};
   endfunction

   function automatic word_type quo_sat(input logic [DIV_BITS-1:0] quo);
      logic [DIV_BITS-1:0] q;
      q = quo - QUO_OFFSET;
      if ((&q[DIV_BITS-1:WORD_BITS-1]) || (~|q[DIV_BITS-1:WORD_BITS-1])) begin
         return q[WORD_BITS-1:0];
      end else begin
         return q[DIV_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                              : {1'b0, {(WORD_BITS-1){1'b1}}};
      end
   endfunction

   assign sum_lane[0] = sum_x;
   assign sum_lane[1] = sum_v;

   always_comb begin
      logic [6:0] step;
      step    = '0;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      for (int l = 0; l < 2; l++) begin
         dvd_in[l] = dvd_ff[l];
         quo_in[l] = quo_ff[l];
         rem_in[l] = rem_ff[l];
      end
      if (start) begin
         for (int l = 0; l < 2; l++) begin
            dvd_in[l] = DIV_BITS'(sum_lane[l]) + DIV_BITS'(3) + DIV_BIAS;
            quo_in[l] = '0;
            rem_in[l] = '0;
         end
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int l = 0; l < 2; l++) begin
            step      = div6_digit({rem_ff[l], dvd_ff[l][DIV_BITS-1 -: 4]});
            dvd_in[l] = dvd_ff[l] << 4;
            quo_in[l] = {quo_ff[l][DIV_BITS-5:0], step[6:3]};
            rem_in[l] = step[2:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(DIV_DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         dvd_ff[l] <= dvd_in[l];
         quo_ff[l] <= quo_in[l];
         rem_ff[l] <= rem_in[l];
      end
   end

   assign quo_out[0] = quo_sat(quo_ff[0]);
   assign quo_out[1] = quo_sat(quo_ff[1]);
   assign quo_x = quo_out[0];
   assign quo_v = quo_out[1];
   assign done  = done_ff;

endmodule

[hdl/rk4_damped_oscillator_step.sv]
// ----------------------------------------------------------------------------
// rk4_damped_oscillator_step - RK4 integrator for a damped oscillator
// Load or advance x, v of a = -k*x - beta*v in Q8.24, one step per request.
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    opcode, start_position, start_velocity
//   rsp_if   out  valid/ready    position, velocity, steps_done, crossed_zero,
//                                finished
//   csr_*    in   write enable   csr_index, csr_write_data
//
// A step request passes through the four RK stages on the shared multiplier
// (each product is rounded the cycle after it is issued), then through the
// divide-by-six unit (start, ten digits, done), then update and result; the
// next request is taken in idle. A load, or a step once finished, goes from
// idle straight to the result state.
// Synchronous reset clears the state and restores the register defaults.
// A new request is taken only in idle; a waiting response does not block the
// next request, only the next response.
// ----------------------------------------------------------------------------
module rk4_damped_oscillator_step (
   input  logic                                 clock,
   input  logic                                 reset,
   rk4o_req_if.sink                             req_if,
   rk4o_rsp_if.source                           rsp_if,
   input  logic                                 csr_write_en,
   input  logic [rk4o_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rk4o_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import rk4o_pkg::*;

   state_type state_ff, state_in;

   logic [DAMPING_BITS-1:0]   damping_ff;
   logic [STIFFNESS_BITS-1:0] stiffness_ff;
   logic [TIME_STEP_BITS-1:0] time_step_ff;
   logic [STEP_BITS-1:0]      step_limit_ff;

   word_type               pos_ff, pos_in;
   word_type               vel_ff, vel_in;
   logic [STEP_BITS-1:0]   step_cnt_ff, step_cnt_in;
   logic                   crossed_ff, crossed_in;

   word_type               xs_ff, xs_in;
   word_type               vs_ff, vs_in;
   word_type               p1_ff, p1_in;
   word_type               p2_ff, p2_in;
   word_type               acc_ff, acc_in;
   word_type               dx_ff, dx_in;
   word_type               dv_ff, dv_in;
   sum_type                sumx_ff, sumx_in;
   sum_type                sumv_ff, sumv_in;
   logic [STAGE_BITS-1:0]  stage_ff, stage_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   word_type               rsp_pos_ff, rsp_pos_in;
   word_type               rsp_vel_ff, rsp_vel_in;
   logic [STEP_BITS-1:0]   rsp_steps_ff, rsp_steps_in;
   logic                   rsp_crossed_ff, rsp_crossed_in;
   logic                   rsp_fin_ff, rsp_fin_in;

   word_type               mul_a, mul_b, mul_res;
   word_type               dt_word;
   word_type               quo_x, quo_v;
   logic                   div_start, div_done;
   logic                   finished;
   logic                   twice;
   logic                   full;
   word_type               pos_new;

   function automatic word_type add_sat(input word_type a, input word_type b);
      logic signed [WORD_BITS:0] s;
      s = (WORD_BITS+1)'(a) + (WORD_BITS+1)'(b);
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                             : {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      return s[WORD_BITS-1:0];
   endfunction

   function automatic word_type neg_sat(input word_type a);
      if (a == {1'b1, {(WORD_BITS-1){1'b0}}}) begin
         return {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      return -a;
   endfunction

   rk4o_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .mul_res (mul_res)
   );

   rk4o_div6 u_div6 (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum_x (sumx_ff),
      .sum_v (sumv_ff),
      .done  (div_done),
      .quo_x (quo_x),
      .quo_v (quo_v)
   );

   assign dt_word  = word_type'(WORD_BITS'(time_step_ff));
   assign finished = crossed_ff || (step_cnt_ff >= step_limit_ff);
   // middle stages carry weight two in the final sum
   assign twice    = stage_ff[0] ^ stage_ff[1];
   assign full     = (stage_ff == STAGE_FULL);
   assign pos_new  = add_sat(pos_ff, quo_x);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff    <= DAMPING_RESET;
         stiffness_ff  <= STIFFNESS_RESET;
         time_step_ff  <= TIME_STEP_RESET;
         step_limit_ff <= STEP_LIMIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DAMPING:    damping_ff    <= csr_write_data[DAMPING_BITS-1:0];
            CSR_STIFFNESS:  stiffness_ff  <= csr_write_data[STIFFNESS_BITS-1:0];
            CSR_TIME_STEP:  time_step_ff  <= csr_write_data[TIME_STEP_BITS-1:0];
            CSR_STEP_LIMIT: step_limit_ff <= csr_write_data[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      vel_in         = vel_ff;
      step_cnt_in    = step_cnt_ff;
      crossed_in     = crossed_ff;
      xs_in          = xs_ff;
      vs_in          = vs_ff;
      p1_in          = p1_ff;
      p2_in          = p2_ff;
      acc_in         = acc_ff;
      dx_in          = dx_ff;
      dv_in          = dv_ff;
      sumx_in        = sumx_ff;
      sumv_in        = sumv_ff;
      stage_in       = stage_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_pos_in     = rsp_pos_ff;
      rsp_vel_in     = rsp_vel_ff;
      rsp_steps_in   = rsp_steps_ff;
      rsp_crossed_in = rsp_crossed_ff;
      rsp_fin_in     = rsp_fin_ff;
      mul_a          = vs_ff;
      mul_b          = dt_word;
      div_start      = 1'b0;
      req_if.ready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               if (req_if.opcode == OP_LOAD) begin
                  pos_in      = req_if.start_position;
                  vel_in      = req_if.start_velocity;
                  step_cnt_in = '0;
                  crossed_in  = 1'b0;
                  state_in    = ST_RESULT;
               end else if (finished) begin
                  state_in = ST_RESULT;
               end else begin
                  xs_in    = pos_ff;
                  vs_in    = vel_ff;
                  sumx_in  = '0;
                  sumv_in  = '0;
                  stage_in = '0;
                  state_in = ST_MUL_KX;
               end
            end
         end
         ST_MUL_KX: begin
            mul_a    = word_type'(WORD_BITS'(stiffness_ff));
            mul_b    = xs_ff;
            state_in = ST_MUL_DV;
         end
         ST_MUL_DV: begin
            mul_a    = word_type'(WORD_BITS'(damping_ff));
            mul_b    = vs_ff;
            p1_in    = mul_res;
            state_in = ST_MUL_VDT;
         end
         ST_MUL_VDT: begin
            mul_a    = vs_ff;
            mul_b    = dt_word;
            p2_in    = mul_res;
            state_in = ST_ACCEL;
         end
         ST_ACCEL: begin
            dx_in    = mul_res;
            sumx_in  = sumx_ff + (twice ? (SUM_BITS'(mul_res) <<< 1) : SUM_BITS'(mul_res));
            acc_in   = add_sat(neg_sat(p1_ff), neg_sat(p2_ff));
            state_in = ST_MUL_ADT;
         end
         ST_MUL_ADT: begin
            mul_a    = acc_ff;
            mul_b    = dt_word;
            xs_in    = add_sat(pos_ff, full ? dx_ff : (dx_ff >>> 1));
            state_in = ST_ROUND_DV;
         end
         ST_ROUND_DV: begin
            dv_in   = mul_res;
            sumv_in = sumv_ff + (twice ? (SUM_BITS'(mul_res) <<< 1) : SUM_BITS'(mul_res));
            state_in = (stage_ff == STAGE_LAST) ? ST_DIV_START : ST_VEL_MID;
         end
         ST_VEL_MID: begin
            vs_in    = add_sat(vel_ff, full ? dv_ff : (dv_ff >>> 1));
            stage_in = stage_ff + 1'b1;
            state_in = ST_MUL_KX;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            pos_in      = pos_new;
            vel_in      = add_sat(vel_ff, quo_v);
            step_cnt_in = step_cnt_ff + 1'b1;
            crossed_in  = crossed_ff | pos_new[WORD_BITS-1];
            state_in    = ST_RESULT;
         end
         ST_RESULT: begin
            // output register free or emptied by a transfer this cycle
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_pos_in     = pos_ff;
               rsp_vel_in     = vel_ff;
               rsp_steps_in   = step_cnt_ff;
               rsp_crossed_in = crossed_ff;
               rsp_fin_in     = finished;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         vel_ff       <= '0;
         step_cnt_ff  <= '0;
         crossed_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         step_cnt_ff  <= step_cnt_in;
         crossed_ff   <= crossed_in;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff          <= xs_in;
      vs_ff          <= vs_in;
      p1_ff          <= p1_in;
      p2_ff          <= p2_in;
      acc_ff         <= acc_in;
      dx_ff          <= dx_in;
      dv_ff          <= dv_in;
      sumx_ff        <= sumx_in;
      sumv_ff        <= sumv_in;
      stage_ff       <= stage_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_vel_ff     <= rsp_vel_in;
      rsp_steps_ff   <= rsp_steps_in;
      rsp_crossed_ff <= rsp_crossed_in;
      rsp_fin_ff     <= rsp_fin_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.position     = 32'(rsp_pos_ff);
   assign rsp_if.velocity     = 32'(rsp_vel_ff);
   assign rsp_if.steps_done   = rsp_steps_ff;
   assign rsp_if.crossed_zero = rsp_crossed_ff;
   assign rsp_if.finished     = rsp_fin_ff;

   // an update only happens on a live integration
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (step_cnt_ff < step_limit_ff) && !crossed_ff)
      else $error("step taken after finish");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> step_cnt_ff == STEP_BITS'($past(step_cnt_ff) + 1'b1))
      else $error("step count did not advance by one");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (!rsp_if.crossed_zero || rsp_if.finished))
      else $error("crossed without finished");

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider done outside wait state");

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - testbench for the RK4 damped oscillator stepper
// Drives load and step requests with random gaps, stalls the response side at
// random, and compares every response against a fixed-point RK4 predictor
// that tracks position, velocity, step count and the sticky crossing flag.
// ----------------------------------------------------------------------------
module tb_top;
   import rk4o_pkg::*;

   localparam int          RANDOM_ITEMS = 1500;
   localparam int          MAX_WAIT     = 17;
   localparam int          TAIL_CYCLES  = 64;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          REPORT_LIMIT = 10;

   localparam longint          WORD_MAX   = (64'sd1 <<< (WORD_BITS - 1)) - 1;
   localparam longint          WORD_MIN   = -WORD_MAX - 1;
   localparam longint unsigned ROUND_HALF = 64'd1 << (FRAC_BITS - 1);
   localparam word_type        Q_ONE      = word_type'(64'sd1 <<< FRAC_BITS);

   typedef struct packed {
      word_type               position;
      word_type               velocity;
      logic [STEP_BITS-1:0]   steps_done;
      logic                   crossed_zero;
      logic                   finished;
   } osc_result_type;

   logic clock;
   logic reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   rk4o_req_if req_bus();
   rk4o_rsp_if rsp_bus();

   rk4_damped_oscillator_step u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_bus),
      .rsp_if         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // predictor copy of the registers and the integrator state
   longint               cfg_damping    = longint'(DAMPING_RESET);
   longint               cfg_stiffness  = longint'(STIFFNESS_RESET);
   longint               cfg_time_step  = longint'(TIME_STEP_RESET);
   logic [STEP_BITS-1:0] cfg_step_limit = STEP_LIMIT_RESET;
   longint               osc_pos        = 0;
   longint               osc_vel        = 0;
   logic [STEP_BITS-1:0] osc_steps      = '0;
   logic                 osc_crossed    = 1'b0;

   osc_result_type expected_responses[$];
   int          requests_sent  = 0;
   int          responses_seen = 0;
   int          fault_count    = 0;
   int          cycle_count    = 0;
   bit          quiet_spell    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint clamp_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   function automatic longint sat_add(longint a, longint b);
      return clamp_word(a + b);
   endfunction

   // product of magnitudes, round half away from zero, saturate
   function automatic longint qmul(longint a, longint b);
      longint unsigned ma, mb, r;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      r  = (ma * mb + ROUND_HALF) >> FRAC_BITS;
      if ((a < 0) != (b < 0))
         return (r > WORD_MAX + 1) ? WORD_MIN : -longint'(r);
      return (r > WORD_MAX) ? WORD_MAX : longint'(r);
   endfunction

   function automatic longint accel_of(longint x, longint v);
      return sat_add(clamp_word(-qmul(cfg_stiffness, x)), clamp_word(-qmul(cfg_damping, v)));
   endfunction

   // (k0 + 2k1 + 2k2 + k3) / 6, nearest with ties upward
   function automatic longint weighted_sixth(longint k0, longint k1, longint k2, longint k3);
      longint n, q;
      n = k0 + 2 * k1 + 2 * k2 + k3 + 3;
      q = n / 6;
      if (n < 0 && n % 6 != 0) q = q - 1;
      return clamp_word(q);
   endfunction

   function automatic void rk4_advance();
      longint dx[4];
      longint dv[4];
      longint xs, vs;
      xs = osc_pos;
      vs = osc_vel;
      for (int i = 0; i < 4; i++) begin
         dv[i] = qmul(accel_of(xs, vs), cfg_time_step);
         dx[i] = qmul(vs, cfg_time_step);
         // half increments for the middle stages, full one for the last
         xs = sat_add(osc_pos, (i == 2) ? dx[i] : (dx[i] >>> 1));
         vs = sat_add(osc_vel, (i == 2) ? dv[i] : (dv[i] >>> 1));
      end
      osc_pos = sat_add(osc_pos, weighted_sixth(dx[0], dx[1], dx[2], dx[3]));
      osc_vel = sat_add(osc_vel, weighted_sixth(dv[0], dv[1], dv[2], dv[3]));
   endfunction

   function automatic osc_result_type expected_response_for(opcode_type op, word_type p,
                                                            word_type v);
      osc_result_type r;
      if (op == OP_LOAD) begin
         osc_pos     = longint'(p);
         osc_vel     = longint'(v);
         osc_steps   = '0;
         osc_crossed = 1'b0;
      end else if (!(osc_crossed || osc_steps >= cfg_step_limit)) begin
         rk4_advance();
         osc_steps = osc_steps + 1'b1;
         if (osc_pos < 0) osc_crossed = 1'b1;
      end
      r.position     = word_type'(osc_pos);
      r.velocity     = word_type'(osc_vel);
      r.steps_done   = osc_steps;
      r.crossed_zero = osc_crossed;
      r.finished     = osc_crossed || (osc_steps >= cfg_step_limit);
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   function automatic int unsigned draw_wait();
      return quiet_spell ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic word_type draw_state_value();
      case ($urandom_range(0, 9))
         0:       return word_type'(WORD_MAX);
         1:       return word_type'(WORD_MIN);
         2:       return word_type'($urandom);
         3:       return '0;
         default: return word_type'(int'($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
      endcase
   endfunction

   // valid is left high after the transfer; the next call drops it for a gap, or the drain drops it
   task automatic send_request(opcode_type op, word_type p, word_type v);
      int unsigned gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.opcode         <= op;
      req_bus.start_position <= p;
      req_bus.start_velocity <= v;
      do @(posedge clock); while (!(req_bus.valid === 1'b1 && req_bus.ready === 1'b1));
      expected_responses.push_back(expected_response_for(op, p, v));
      requests_sent++;
   endtask

   task automatic send_step();
      send_request(OP_STEP, word_type'($urandom), word_type'($urandom));
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         CSR_DAMPING:    cfg_damping    = longint'(value[DAMPING_BITS-1:0]);
         CSR_STIFFNESS:  cfg_stiffness  = longint'(value[STIFFNESS_BITS-1:0]);
         CSR_TIME_STEP:  cfg_time_step  = longint'(value[TIME_STEP_BITS-1:0]);
         CSR_STEP_LIMIT: cfg_step_limit = value[STEP_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(logic [CSR_DATA_BITS-1:0] damping,
                            logic [CSR_DATA_BITS-1:0] stiffness,
                            logic [CSR_DATA_BITS-1:0] time_step,
                            logic [CSR_DATA_BITS-1:0] step_limit);
      write_register(CSR_DAMPING, damping);
      write_register(CSR_STIFFNESS, stiffness);
      write_register(CSR_TIME_STEP, time_step);
      write_register(CSR_STEP_LIMIT, step_limit);
   endtask

   // response side: random stall before each transfer
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = draw_wait();
         @(negedge clock);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
      end
   end

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      osc_result_type got, want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.position     = rsp_bus.position;
         got.velocity     = rsp_bus.velocity;
         got.steps_done   = rsp_bus.steps_done;
         got.crossed_zero = rsp_bus.crossed_zero;
         got.finished     = rsp_bus.finished;
         if (expected_responses.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("response transfer %0d with nothing expected: pos=%h vel=%h",
                        responses_seen, got.position, got.velocity);
         end else begin
            want = expected_responses.pop_front();
            if (got.position !== want.position || got.velocity !== want.velocity ||
                got.steps_done !== want.steps_done ||
                got.crossed_zero !== want.crossed_zero || got.finished !== want.finished) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display({"response %0d mismatch:\n",
                            "  expected pos=%h vel=%h steps=%0d crossed=%b finished=%b\n",
                            "  actual   pos=%h vel=%h steps=%0d crossed=%b finished=%b"},
                           responses_seen,
                           want.position, want.velocity, want.steps_done,
                           want.crossed_zero, want.finished,
                           got.position, got.velocity, got.steps_done,
                           got.crossed_zero, got.finished);
            end
         end
         responses_seen++;
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_reset_state();
      // state is zero out of reset, so a step keeps it there and counts
      send_step();
   endtask

   task automatic test_load_extremes();
      send_request(OP_LOAD, word_type'(WORD_MAX), word_type'(WORD_MIN));
      send_request(OP_LOAD, word_type'(WORD_MIN), word_type'(WORD_MAX));
      // negative position on load leaves the crossing flag clear
      send_request(OP_LOAD, -1, '0);
      send_request(OP_LOAD, '0, -1);
   endtask

   task automatic test_default_motion();
      send_request(OP_LOAD, Q_ONE, '0);
      repeat (3) send_step();
      send_request(OP_LOAD, -(Q_ONE >>> 1), -Q_ONE);
      send_step();
      send_step();   // held after crossing
   endtask

   task automatic test_step_limit();
      wait_until_drained();
      configure('0, STIFFNESS_RESET, 31'h0010_0000, 31'd1);
      send_request(OP_LOAD, Q_ONE, Q_ONE >>> 1);
      send_step();
      send_step();   // held at the limit
      wait_until_drained();
      // a zero limit holds every step and reads finished right after load
      write_register(CSR_STEP_LIMIT, '0);
      send_request(OP_LOAD, Q_ONE, '0);
      send_step();
   endtask

   task automatic test_saturation();
      wait_until_drained();
      // step above one with the largest coefficients
      configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h01FF_FFFF, 31'h000F_FFFF);
      send_request(OP_LOAD, word_type'(WORD_MAX), word_type'(WORD_MAX));
      send_step();
      send_request(OP_LOAD, word_type'(WORD_MIN), word_type'(WORD_MIN));
      send_step();
      wait_until_drained();
      // zero step: state unchanged but steps still counted
      write_register(CSR_TIME_STEP, '0);
      send_request(OP_LOAD, Q_ONE, Q_ONE);
      send_step();
   endtask

   task automatic test_random_runs();
      int random_end, phase_end, run_len;
      logic [CSR_DATA_BITS-1:0] damping, stiffness, time_step, step_limit;
      random_end = requests_sent + RANDOM_ITEMS;
      while (requests_sent < random_end) begin
         wait_until_drained();
         case ($urandom_range(0, 5))
            0:       damping = '0;
            1:       damping = 31'h7FFF_FFFF;
            2:       damping = CSR_DATA_BITS'($urandom);
            default: damping = CSR_DATA_BITS'($urandom_range(0, 32'h0400_0000));
         endcase
         case ($urandom_range(0, 5))
            0:       stiffness = '0;
            1:       stiffness = 31'h7FFF_FFFF;
            2:       stiffness = CSR_DATA_BITS'($urandom);
            default: stiffness = CSR_DATA_BITS'($urandom_range(32'h0100_0000, 32'h1000_0000));
         endcase
         case ($urandom_range(0, 5))
            0:       time_step = 31'd1;
            1:       time_step = 31'h0100_0000;
            2:       time_step = CSR_DATA_BITS'($urandom);   // upper bits dropped
            default: time_step = CSR_DATA_BITS'($urandom_range(32'h0008_0000, 32'h0080_0000));
         endcase
         case ($urandom_range(0, 5))
            0:       step_limit = 31'd1;
            1:       step_limit = 31'h000F_FFFF;
            2:       step_limit = CSR_DATA_BITS'($urandom_range(1, 2000));
            default: step_limit = CSR_DATA_BITS'($urandom_range(1, 40));
         endcase
         configure(damping, stiffness, time_step, step_limit);

         phase_end = requests_sent + $urandom_range(40, 160);
         while (requests_sent < phase_end && requests_sent < random_end) begin
            quiet_spell = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
               // noise: arbitrary opcodes and payloads
               repeat ($urandom_range(1, 6))
                  send_request(opcode_type'($urandom_range(0, 1)), word_type'($urandom),
                               word_type'($urandom));
            end else begin
               send_request(OP_LOAD, draw_state_value(), draw_state_value());
               run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 150)
                                                     : $urandom_range(1, 30);
               repeat (run_len) send_step();
            end
         end
         quiet_spell = 1'b0;
      end
   endtask

   initial begin
      reset                  = 1'b1;
      csr_write_en           = 1'b0;
      csr_index              = CSR_DAMPING;
      csr_write_data         = '0;
      req_bus.valid          = 1'b0;
      req_bus.opcode         = OP_LOAD;
      req_bus.start_position = '0;
      req_bus.start_velocity = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_load_extremes();
      test_default_motion();
      test_step_limit();
      test_saturation();
      test_random_runs();

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
hdl/rk4o_pkg.sv
hdl/rk4o_req_if.sv
hdl/rk4o_rsp_if.sv
hdl/rk4o_mul.sv
hdl/rk4o_div6.sv
hdl/rk4_damped_oscillator_step.sv
test/tb_top.sv
